// ===== design/kmca_pkg.sv =====
// ----------------------------------------------------------------------------
// kmca_pkg
// Shared types and constants of the keyboard MIDI channel allocator: payload
// structs, command codes, register indexes and the key layout tables.
// ----------------------------------------------------------------------------
package kmca_pkg;

   // Input operation codes
   localparam logic [1:0] OP_PRESS   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_SCALE_SELECT   = 2'd0;
   localparam logic [1:0] CSR_VOLUME_PERCENT = 2'd1;
   localparam logic [1:0] CSR_RELEASE_DELAY  = 2'd2;

   localparam logic [4:0]  SCALE_RESET   = 5'd7;
   localparam logic [6:0]  VOLUME_RESET  = 7'd100;
   localparam logic [15:0] DELAY_RESET   = 16'd1500;
   localparam logic [6:0]  VELOCITY_RESET = 7'((100 * 127 + 50) / 100);

   // Scale selection: 0..11 major, 12..23 minor
   localparam logic [4:0] SCALE_MAX       = 5'd23;
   localparam logic [4:0] SCALE_MINOR_LOW = 5'd12;
   localparam logic [6:0] MAJOR_BASE      = 7'd48;
   // minor base 45 minus the 12 subtracted from the selector
   localparam logic [6:0] MINOR_BASE      = 7'd33;

   // 2^19 / 100 rounded up; exact floor for numerators below 2^14
   localparam logic [12:0] VEL_RECIP      = 13'd5243;
   localparam int          VEL_SHIFT      = 19;
   localparam logic [6:0]  VELOCITY_MAX   = 7'd127;
   localparam logic [13:0] VEL_ROUND      = 14'd50;

   // MIDI message constants
   localparam logic [7:0] STATUS_NOTE_ON     = 8'h90;
   localparam logic [7:0] STATUS_CONTROL     = 8'hB0;
   localparam logic [6:0] CTRL_ALL_NOTES_OFF = 7'd123;

   // Release countdown slots, one per 4-bit channel number
   localparam int SLOTS     = 16;
   localparam int SLOT_BITS = 4;
   localparam int CHAN_BITS = 4;

   localparam int CMDQ_DEPTH = 2;

   // Semitone offset of each layout index (octave * 12 + scale step)
   localparam logic [5:0] MAJOR_SEMI [21] = '{
      6'd0,  6'd2,  6'd4,  6'd5,  6'd7,  6'd9,  6'd11,
      6'd12, 6'd14, 6'd16, 6'd17, 6'd19, 6'd21, 6'd23,
      6'd24, 6'd26, 6'd28, 6'd29, 6'd31, 6'd33, 6'd35};
   localparam logic [5:0] MINOR_SEMI [21] = '{
      6'd0,  6'd2,  6'd3,  6'd5,  6'd7,  6'd8,  6'd10,
      6'd12, 6'd14, 6'd15, 6'd17, 6'd19, 6'd20, 6'd22,
      6'd24, 6'd26, 6'd27, 6'd29, 6'd31, 6'd32, 6'd34};

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] key_code;
   } req_type;

   typedef struct packed {
      logic [7:0] status_byte;
      logic [6:0] data_one;
      logic [6:0] data_two;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic        write;
      logic [1:0]  index;
      logic [15:0] wdata;
   } csr_type;

   typedef enum logic [1:0] {
      CMD_PRESS,
      CMD_RELEASE,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   key;
      logic [6:0]   pitch;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmdq_push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmdq_head_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRESS,
      ST_RELEASE,
      ST_RELEASE_APPLY,
      ST_TICK_SETUP,
      ST_TICK_SCAN
   } back_state_type;

   // Rows Z..M, A..J, Q..U; anything else falls on the first key
   function automatic logic [4:0] key_layout_index(input logic [7:0] key);
      logic [4:0] idx;
      case (key)
         8'h5A:   idx = 5'd0;   // Z
         8'h58:   idx = 5'd1;   // X
         8'h43:   idx = 5'd2;   // C
         8'h56:   idx = 5'd3;   // V
         8'h42:   idx = 5'd4;   // B
         8'h4E:   idx = 5'd5;   // N
         8'h4D:   idx = 5'd6;   // M
         8'h41:   idx = 5'd7;   // A
         8'h53:   idx = 5'd8;   // S
         8'h44:   idx = 5'd9;   // D
         8'h46:   idx = 5'd10;  // F
         8'h47:   idx = 5'd11;  // G
         8'h48:   idx = 5'd12;  // H
         8'h4A:   idx = 5'd13;  // J
         8'h51:   idx = 5'd14;  // Q
         8'h57:   idx = 5'd15;  // W
         8'h45:   idx = 5'd16;  // E
         8'h52:   idx = 5'd17;  // R
         8'h54:   idx = 5'd18;  // T
         8'h59:   idx = 5'd19;  // Y
         8'h55:   idx = 5'd20;  // U
         default: idx = 5'd0;
      endcase
      return idx;
   endfunction

endpackage

// ===== design/keyboard_midi_channel_allocator.sv =====
// ----------------------------------------------------------------------------
// keyboard_midi_channel_allocator
// Keyboard events to MIDI note-on and all-notes-off messages with a pool of
// free channels and per-channel release timers.
// ----------------------------------------------------------------------------
// The front end takes one event per cycle while its two-entry command queue
// has room; presses and releases of key codes at or above KEY_CODES and the
// unknown operations are dropped there. The back end runs one command at a
// time: a press in ST_PRESS, a release in ST_RELEASE and, for a held key,
// ST_RELEASE_APPLY, a millisecond tick in ST_TICK_SETUP, then ST_TICK_SCAN,
// one of the 16 release countdown slots per cycle; a press and an expiring
// slot wait while the output register holds a result with rsp_ready low. No
// clearing pass is needed after reset. Velocity is registered from volume_ff.
module keyboard_midi_channel_allocator
   import kmca_pkg::*;
#(
   parameter int NUM_CHANNELS = 11,
   parameter int KEY_CODES    = 256,
   parameter int TIMER_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   csr_type       csr;
   cmdq_push_type push;
   cmdq_head_type qhead;
   logic          queue_full;
   logic          pop;
   logic [6:0]    velocity;

   assign csr.write = csr_write;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   kmca_front #(
      .KEY_CODES (KEY_CODES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr        (csr),
      .queue_full (queue_full),
      .push       (push),
      .velocity   (velocity)
   );

   kmca_cmd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (qhead)
   );

   kmca_back #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .KEY_CODES    (KEY_CODES),
      .TIMER_BITS   (TIMER_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .qhead     (qhead),
      .pop       (pop),
      .velocity  (velocity),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/kmca_ram.sv =====
// ----------------------------------------------------------------------------
// kmca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmca_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/kmca_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// kmca_cmd_queue
// Short command FIFO between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module kmca_cmd_queue
   import kmca_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmdq_push_type push,
   output logic          full,
   input  logic          pop,
   output cmdq_head_type head
);

   localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CW = $clog2(CMDQ_DEPTH + 1);

   cmd_type         entries_ff [CMDQ_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(CMDQ_DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// ===== design/kmca_front.sv =====
// ----------------------------------------------------------------------------
// kmca_front
// Input side: accepts events, drops the ones with no effect, maps key codes
// to pitch and keeps the scale and volume settings.
// ----------------------------------------------------------------------------
module kmca_front
   import kmca_pkg::*;
#(
   parameter int KEY_CODES = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   input  csr_type       csr,
   input  logic          queue_full,
   output cmdq_push_type push,
   output logic [6:0]    velocity
);

   logic [4:0]  scale_ff, scale_in;
   logic [6:0]  volume_ff, volume_in;
   logic [6:0]  vel_ff, vel_in;

   logic        accept;
   logic        in_range;
   logic        keep;
   logic [4:0]  sel;
   logic        minor;
   logic [4:0]  layout_idx;
   logic [5:0]  semi;
   logic [6:0]  pitch;
   logic [13:0] vel_num;
   logic [26:0] vel_prod;
   logic [7:0]  vel_quot;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign in_range  = ({1'b0, req_data.key_code} < 9'(KEY_CODES));

   // pitch from layout index and scale
   assign sel        = (scale_ff > SCALE_MAX) ? SCALE_MAX : scale_ff;
   assign minor      = (sel >= SCALE_MINOR_LOW);
   assign layout_idx = key_layout_index(req_data.key_code);
   assign semi       = minor ? MINOR_SEMI[layout_idx] : MAJOR_SEMI[layout_idx];
   assign pitch      = (minor ? MINOR_BASE : MAJOR_BASE) + {2'd0, sel} + {1'b0, semi};

   always_comb begin
      push.cmd.key   = req_data.key_code;
      push.cmd.pitch = pitch;
      case (req_data.operation)
         OP_PRESS: begin
            keep          = in_range;
            push.cmd.kind = CMD_PRESS;
         end
         OP_RELEASE: begin
            keep          = in_range;
            push.cmd.kind = CMD_RELEASE;
         end
         OP_TICK: begin
            keep          = 1'b1;
            push.cmd.kind = CMD_TICK;
         end
         default: begin
            keep          = 1'b0;
            push.cmd.kind = CMD_TICK;
         end
      endcase
      push.valid = accept && keep;
   end

   // velocity = round(volume * 127 / 100), saturated
   assign vel_num  = {volume_ff, 7'd0} - {7'd0, volume_ff} + VEL_ROUND;
   assign vel_prod = 27'(vel_num) * 27'(VEL_RECIP);
   assign vel_quot = vel_prod[VEL_SHIFT +: 8];
   assign vel_in   = (vel_quot > 8'(VELOCITY_MAX)) ? VELOCITY_MAX : vel_quot[6:0];
   assign velocity = vel_ff;

   always_comb begin
      scale_in  = scale_ff;
      volume_in = volume_ff;
      if (csr.write && csr.index == CSR_SCALE_SELECT) begin
         scale_in = csr.wdata[4:0];
      end
      if (csr.write && csr.index == CSR_VOLUME_PERCENT) begin
         volume_in = csr.wdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RESET;
         volume_ff <= VOLUME_RESET;
         vel_ff    <= VELOCITY_RESET;
      end else begin
         scale_ff  <= scale_in;
         volume_ff <= volume_in;
         vel_ff    <= vel_in;
      end
   end

endmodule

// ===== design/kmca_back.sv =====
// ----------------------------------------------------------------------------
// kmca_back
// Execution side: owns the held-key table, free channel FIFO and release
// countdowns, and issues note-on and all-notes-off messages.
// ----------------------------------------------------------------------------
module kmca_back
   import kmca_pkg::*;
#(
   parameter int NUM_CHANNELS = 11,
   parameter int KEY_CODES    = 256,
   parameter int TIMER_BITS   = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  csr_type       csr,
   input  cmdq_head_type qhead,
   output logic          pop,
   input  logic [6:0]    velocity,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   localparam int KW = $clog2(KEY_CODES);
   localparam int HW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CW = $clog2(NUM_CHANNELS + 1);
   localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [KEY_CODES-1:0]  held_ff, held_in;
   logic [CHAN_BITS-1:0]  free_ff [NUM_CHANNELS];
   logic [CHAN_BITS-1:0]  free_in [NUM_CHANNELS];
   logic [HW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [TIMER_BITS-1:0] countdown_ff [SLOTS];
   logic [TIMER_BITS-1:0] countdown_in [SLOTS];
   logic [SLOTS-1:0]      pending_ff, pending_in;
   logic [SLOTS-1:0]      mask_ff, mask_in;
   logic [SLOT_BITS-1:0]  scan_ff, scan_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [15:0]           delay_ff, delay_in;

   logic                  out_free;
   logic [KW-1:0]         key_idx;
   logic [CHAN_BITS-1:0]  head_ch;
   logic [CW:0]           tail_sum;
   logic [CW:0]           tail_wrap;
   logic [HW-1:0]         tail;
   logic [31:0]           delay_wide;
   logic [TIMER_BITS-1:0] delay_sat;
   logic [SLOTS-1:0]      expire;
   logic [SLOTS-1:0]      remaining;
   logic                  advance;
   logic                  ram_we;
   logic [CHAN_BITS-1:0]  ram_rdata;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign key_idx  = cmd_ff.key[KW-1:0];
   assign head_ch  = free_ff[head_ff];

   assign tail_sum  = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign tail_wrap = (tail_sum >= (CW + 1)'(NUM_CHANNELS)) ?
                      tail_sum - (CW + 1)'(NUM_CHANNELS) : tail_sum;
   assign tail      = tail_wrap[HW-1:0];

   assign delay_wide = {16'd0, delay_ff};
   assign delay_sat  = (delay_wide > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0]
                                                : delay_wide[TIMER_BITS-1:0];

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         expire[i] = pending_ff[i] && (countdown_ff[i][TIMER_BITS-1:1] == '0);
      end
   end

   assign remaining = mask_ff & ~(SLOTS'(1) << scan_ff);

   kmca_ram #(
      .WIDTH (CHAN_BITS),
      .DEPTH (KEY_CODES)
   ) u_key_chan (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (key_idx),
      .wr_data (head_ch),
      .rd_addr (key_idx),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      held_in      = held_ff;
      free_in      = free_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      countdown_in = countdown_ff;
      pending_in   = pending_ff;
      mask_in      = mask_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      ram_we       = 1'b0;
      advance      = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (qhead.valid) begin
               pop    = 1'b1;
               cmd_in = qhead.cmd;
               case (qhead.cmd.kind)
                  CMD_PRESS:   state_in = ST_PRESS;
                  CMD_RELEASE: state_in = ST_RELEASE;
                  CMD_TICK:    state_in = ST_TICK_SETUP;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_PRESS: begin
            if (held_ff[key_idx] || count_ff == '0) begin
               // drop: key already held or no channel free
               state_in = ST_IDLE;
            end else if (out_free) begin
               ram_we               = 1'b1;
               held_in[key_idx]     = 1'b1;
               head_in              = (head_ff == HW'(NUM_CHANNELS - 1)) ? '0
                                                                         : head_ff + 1'b1;
               count_in             = count_ff - 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_in.status_byte   = STATUS_NOTE_ON | {4'd0, head_ch};
               rsp_in.data_one      = cmd_ff.pitch;
               rsp_in.data_two      = velocity;
               rsp_in.last_of_run   = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         ST_RELEASE: begin
            // channel read is under way; skip when the key is not held
            state_in = held_ff[key_idx] ? ST_RELEASE_APPLY : ST_IDLE;
         end
         ST_RELEASE_APPLY: begin
            held_in[key_idx]        = 1'b0;
            countdown_in[ram_rdata] = delay_sat;
            pending_in[ram_rdata]   = 1'b1;
            state_in                = ST_IDLE;
         end
         ST_TICK_SETUP: begin
            mask_in  = expire;
            scan_in  = '0;
            state_in = ST_TICK_SCAN;
         end
         ST_TICK_SCAN: begin
            if (pending_ff[scan_ff]) begin
               if (mask_ff[scan_ff]) begin
                  if (out_free) begin
                     pending_in[scan_ff]   = 1'b0;
                     countdown_in[scan_ff] = '0;
                     mask_in[scan_ff]      = 1'b0;
                     if (count_ff < CW'(NUM_CHANNELS)) begin
                        free_in[tail] = scan_ff;
                        count_in      = count_ff + 1'b1;
                     end
                     rsp_valid_in       = 1'b1;
                     rsp_in.status_byte = STATUS_CONTROL | {4'd0, scan_ff};
                     rsp_in.data_one    = CTRL_ALL_NOTES_OFF;
                     rsp_in.data_two    = '0;
                     rsp_in.last_of_run = (remaining == '0);
                  end else begin
                     advance = 1'b0;   // hold until the output register drains
                  end
               end else begin
                  countdown_in[scan_ff] = countdown_ff[scan_ff] - 1'b1;
               end
            end
            if (advance) begin
               scan_in = scan_ff + 1'b1;
               if (scan_ff == SLOT_BITS'(SLOTS - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      delay_in = delay_ff;
      if (csr.write && csr.index == CSR_RELEASE_DELAY) begin
         delay_in = csr.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= CW'(NUM_CHANNELS);
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         delay_ff     <= DELAY_RESET;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            free_ff[i] <= CHAN_BITS'((i < 9) ? i : i + 1);
         end
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         delay_ff     <= delay_in;
         free_ff      <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      countdown_ff <= countdown_in;
      mask_ff      <= mask_in;
      scan_ff      <= scan_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(NUM_CHANNELS))
      else $error("free channel count exceeds channel total");

   a_release_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RELEASE_APPLY |-> held_ff[key_idx])
      else $error("release applied to a key that is not held");

   a_mask_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TICK_SCAN |-> (mask_ff & ~pending_ff) == '0)
      else $error("expiring slot is not pending");

   a_press_takes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRESS && ram_we) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("note-on did not take a channel from the free list");

endmodule

// ===== tb/sv/midi_message_checker.sv =====
// ----------------------------------------------------------------------------
// midi_message_checker
// Watches the event, MIDI and register ports of the channel allocator, keeps
// its own copy of the channel pool, key ownership and release timers, and
// matches every MIDI message leaving the block against the predicted one.
// ----------------------------------------------------------------------------
module midi_message_checker
   import kmca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          awaiting_count
);

   localparam int CHANNEL_COUNT = 11;
   localparam int MAJOR_STEP [7] = '{0, 2, 4, 5, 7, 9, 11};
   localparam int MINOR_STEP [7] = '{0, 2, 3, 5, 7, 8, 10};

   logic [4:0]  scale_sel;
   logic [6:0]  volume;
   logic [15:0] hold_ticks;

   logic [3:0]  free_ring [CHANNEL_COUNT];
   int          ring_head;
   int          ring_count;
   logic        key_held [256];
   logic [3:0]  key_chan [256];
   logic [15:0] countdown [SLOTS];
   logic        armed [SLOTS];

   rsp_type     midi_expected [$];
   int          faults;

   function automatic int key_row_index(input logic [7:0] key);
      case (key)
         "Z": return 0;   "X": return 1;   "C": return 2;   "V": return 3;
         "B": return 4;   "N": return 5;   "M": return 6;   "A": return 7;
         "S": return 8;   "D": return 9;   "F": return 10;  "G": return 11;
         "H": return 12;  "J": return 13;  "Q": return 14;  "W": return 15;
         "E": return 16;  "R": return 17;  "T": return 18;  "Y": return 19;
         "U": return 20;
         default: return 0;
      endcase
   endfunction

   function automatic logic [6:0] note_pitch(input logic [7:0] key);
      int sel;
      int idx;
      sel = (scale_sel > 5'd23) ? 23 : int'(scale_sel);
      idx = key_row_index(key);
      if (sel < 12) begin
         return 7'(48 + sel + 12 * (idx / 7) + MAJOR_STEP[idx % 7]);
      end
      return 7'(45 + sel - 12 + 12 * (idx / 7) + MINOR_STEP[idx % 7]);
   endfunction

   function automatic logic [6:0] note_velocity();
      int v;
      v = (int'(volume) * 127 + 50) / 100;
      return (v > 127) ? 7'd127 : 7'(v);
   endfunction

   // Advance the voice state by one event and queue the messages it causes
   task automatic play_event(input req_type ev);
      logic [3:0] ch;
      rsp_type    msg;
      rsp_type    held_msg;
      logic       have_msg;
      have_msg = 1'b0;
      held_msg = '0;
      case (ev.operation)
         OP_PRESS: begin
            if (!key_held[ev.key_code] && ring_count > 0) begin
               ch = free_ring[ring_head];
               ring_head = (ring_head + 1) % CHANNEL_COUNT;
               ring_count--;
               key_held[ev.key_code] = 1'b1;
               key_chan[ev.key_code] = ch;
               msg.status_byte = STATUS_NOTE_ON | {4'd0, ch};
               msg.data_one    = note_pitch(ev.key_code);
               msg.data_two    = note_velocity();
               msg.last_of_run = 1'b1;
               midi_expected.push_back(msg);
            end
         end
         OP_RELEASE: begin
            if (key_held[ev.key_code]) begin
               ch = key_chan[ev.key_code];
               key_held[ev.key_code] = 1'b0;
               key_chan[ev.key_code] = 4'd0;
               countdown[ch] = hold_ticks;
               armed[ch] = 1'b1;
            end
         end
         OP_TICK: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (armed[s]) begin
                  if (countdown[s] > 16'd1) begin
                     countdown[s]--;
                  end else begin
                     countdown[s] = 16'd0;
                     armed[s] = 1'b0;
                     if (ring_count < CHANNEL_COUNT) begin
                        free_ring[(ring_head + ring_count) % CHANNEL_COUNT] = 4'(s);
                        ring_count++;
                     end
                     // hold each message back until we know whether it is the last
                     if (have_msg) begin
                        midi_expected.push_back(held_msg);
                     end
                     held_msg.status_byte = STATUS_CONTROL | 8'(s);
                     held_msg.data_one    = CTRL_ALL_NOTES_OFF;
                     held_msg.data_two    = 7'd0;
                     held_msg.last_of_run = 1'b0;
                     have_msg = 1'b1;
                  end
               end
            end
            if (have_msg) begin
               held_msg.last_of_run = 1'b1;
               midi_expected.push_back(held_msg);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         scale_sel  = SCALE_RESET;
         volume     = VOLUME_RESET;
         hold_ticks = DELAY_RESET;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            free_ring[i] = 4'((i < 9) ? i : i + 1);
         end
         ring_head  = 0;
         ring_count = CHANNEL_COUNT;
         for (int k = 0; k < 256; k++) begin
            key_held[k] = 1'b0;
            key_chan[k] = 4'd0;
         end
         for (int s = 0; s < SLOTS; s++) begin
            countdown[s] = 16'd0;
            armed[s]     = 1'b0;
         end
         midi_expected.delete();
         faults = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SCALE_SELECT:   scale_sel  = csr_wdata[4:0];
               CSR_VOLUME_PERCENT: volume     = csr_wdata[6:0];
               CSR_RELEASE_DELAY:  hold_ticks = csr_wdata;
               default: ;
            endcase
         end
         // match outgoing transfers first so a new event cannot satisfy an old message
         if (rsp_valid && rsp_ready) begin
            if (midi_expected.size() == 0) begin
               if (faults < 10) begin
                  $display("unexpected MIDI message: status %02h data %0d,%0d last %0b",
                           rsp_data.status_byte, rsp_data.data_one, rsp_data.data_two,
                           rsp_data.last_of_run);
               end
               faults++;
            end else begin
               want = midi_expected.pop_front();
               if (rsp_data.status_byte !== want.status_byte ||
                   rsp_data.data_one !== want.data_one ||
                   rsp_data.data_two !== want.data_two ||
                   rsp_data.last_of_run !== want.last_of_run) begin
                  if (faults < 10) begin
                     $display({"MIDI mismatch: expected status %02h data %0d,%0d last %0b,",
                               " got status %02h data %0d,%0d last %0b"},
                              want.status_byte, want.data_one, want.data_two,
                              want.last_of_run, rsp_data.status_byte, rsp_data.data_one,
                              rsp_data.data_two, rsp_data.last_of_run);
                  end
                  faults++;
               end
            end
         end
         if (req_valid && req_ready) begin
            play_event(req_data);
         end
      end
      mismatch_count <= faults;
      awaiting_count <= midi_expected.size();
   end

endmodule

// ===== tb/sv/keyboard_midi_channel_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// keyboard_midi_channel_allocator_tb
// Drives key presses, releases and millisecond ticks into the allocator under
// several scale, volume and release delay settings, with random gaps on the
// event side and random back-pressure on the MIDI side. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module keyboard_midi_channel_allocator_tb;
   import kmca_pkg::*;

   // operation code the block ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_valid  = 1'b0;
   logic        req_ready;
   req_type     req_data   = '0;
   logic        rsp_valid;
   logic        rsp_ready  = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write  = 1'b0;
   logic [1:0]  csr_index  = CSR_SCALE_SELECT;
   logic [15:0] csr_wdata  = 16'd0;

   int          mismatch_count;
   int          awaiting_count;
   int          sender_idle_pct = 0;
   int          rsp_stall_pct   = 0;
   logic [7:0]  pressed_keys [$];
   string       layout_keys = "ZXCVBNMASDFGHJQWERTYU";

   keyboard_midi_channel_allocator dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_write, .csr_index, .csr_wdata
   );

   midi_message_checker checker_i (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_write, .csr_index, .csr_wdata,
      .mismatch_count, .awaiting_count
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // One event transfer; valid stays up after acceptance so back-to-back events
   // need no second assignment in the same step
   task automatic send_event(input logic [1:0] op, input logic [7:0] key);
      int  gap;
      logic found;
      gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{operation: op, key_code: key};
      do @(posedge clock); while (!req_ready);
      if (op == OP_PRESS) begin
         found = 1'b0;
         foreach (pressed_keys[i]) begin
            if (pressed_keys[i] == key) found = 1'b1;
         end
         if (!found) pressed_keys.push_back(key);
      end else if (op == OP_RELEASE) begin
         for (int i = pressed_keys.size() - 1; i >= 0; i--) begin
            if (pressed_keys[i] == key) pressed_keys.delete(i);
         end
      end
   endtask

   // Hold off until every message is out, then give the back end time to finish
   // a tick in progress and two more queued ones
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting_count != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic program_regs(input logic [4:0] scale, input logic [6:0] vol,
                               input logic [15:0] ticks);
      csr_write <= 1'b1;
      csr_index <= CSR_SCALE_SELECT;
      csr_wdata <= 16'(scale);
      @(posedge clock);
      csr_index <= CSR_VOLUME_PERCENT;
      csr_wdata <= 16'(vol);
      @(posedge clock);
      csr_index <= CSR_RELEASE_DELAY;
      csr_wdata <= ticks;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Mostly mapped keys and releases of keys that are down, plus stray events
   task automatic random_events(input int count);
      int         roll;
      logic [7:0] key;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 35) begin
            key = ($urandom_range(99) < 70) ? layout_keys[$urandom_range(20)]
                                            : 8'($urandom_range(255));
            send_event(OP_PRESS, key);
         end else if (roll < 65) begin
            if (pressed_keys.size() > 0 && $urandom_range(99) < 75) begin
               key = pressed_keys[$urandom_range(pressed_keys.size() - 1)];
            end else begin
               key = 8'($urandom_range(255));
            end
            send_event(OP_RELEASE, key);
         end else if (roll < 95) begin
            send_event(OP_TICK, 8'($urandom_range(255)));
         end else begin
            send_event(OP_UNUSED, 8'($urandom_range(255)));
         end
      end
   endtask

   task automatic run_phase(input logic [4:0] scale, input logic [6:0] vol,
                            input logic [15:0] ticks, input int idle, input int stall,
                            input int count);
      drain();
      program_regs(scale, vol, ticks);
      sender_idle_pct = idle;
      rsp_stall_pct  <= stall;
      random_events(count);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings; take every channel, then overflow the pool
      send_event(OP_PRESS, "Z");
      send_event(OP_PRESS, "U");
      send_event(OP_PRESS, 8'h00);
      send_event(OP_PRESS, 8'hFF);
      send_event(OP_PRESS, "M");
      send_event(OP_PRESS, "A");
      send_event(OP_PRESS, "X");
      send_event(OP_PRESS, "C");
      send_event(OP_PRESS, "V");
      send_event(OP_PRESS, "B");
      send_event(OP_PRESS, "N");
      send_event(OP_PRESS, "S");
      send_event(OP_PRESS, "Z");
      send_event(OP_RELEASE, "Q");
      send_event(OP_UNUSED, 8'hFF);

      // zero delay: release, then the very next tick frees the channels
      drain();
      program_regs(SCALE_RESET, VOLUME_RESET, 16'd0);
      send_event(OP_RELEASE, "U");
      send_event(OP_RELEASE, 8'h00);
      send_event(OP_TICK, 8'h00);
      send_event(OP_RELEASE, "S");
      send_event(OP_TICK, 8'hFF);
      send_event(OP_RELEASE, "Z");
      send_event(OP_TICK, "A");
      send_event(OP_PRESS, "U");

      run_phase(5'd0,  7'd0,   16'd0, 0,  0,  40);
      run_phase(5'd23, 7'd127, 16'd1, 54, 0,  45);
      run_phase(5'd31, 7'd100, 16'd3, 0,  54, 45);
      run_phase(5'd12, 7'd50,  16'd2, 23, 23, 45);

      // longest delay: the one channel released here stays armed for good
      drain();
      program_regs(5'd11, 7'd1, 16'hFFFF);
      send_event(OP_PRESS, layout_keys[$urandom_range(20)]);
      send_event(OP_PRESS, layout_keys[$urandom_range(20)]);
      if (pressed_keys.size() > 0) send_event(OP_RELEASE, pressed_keys[0]);
      send_event(OP_TICK, 8'h55);
      send_event(OP_TICK, 8'hAA);

      repeat (4) begin
         run_phase(5'($urandom_range(31)), 7'($urandom_range(127)),
                   16'($urandom_range(4)), $urandom_range(1) ? 54 : 0,
                   $urandom_range(1) ? 54 : 0, 20);
      end

      drain();
      if (mismatch_count == 0 && awaiting_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
design/kmca_pkg.sv
design/kmca_ram.sv
design/kmca_cmd_queue.sv
design/kmca_front.sv
design/kmca_back.sv
design/keyboard_midi_channel_allocator.sv
tb/sv/midi_message_checker.sv
tb/sv/keyboard_midi_channel_allocator_tb.sv
